// ===== sv/hts_pkg.sv =====
// Shared types and codes of the heap task scheduler.
`timescale 1ns / 1ps
package hts_pkg;

    localparam int IdW         = 8;
    localparam int DelayW      = 17;
    localparam int PeriodW     = 16;
    localparam int ResultLimit = 16;
    localparam int NumW        = 5;
    localparam int BufW        = 4;

    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_TICK = 2'd1;
    localparam logic [1:0] FUNC_DEL  = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_NODEL = 2'd2;

    // Delay floor after the subtraction pass, -65536 in 17 bits.
    localparam logic [DelayW-1:0] DELAY_FLOOR = 17'h10000;

    typedef struct packed {
        logic [IdW-1:0]            id;
        logic signed [DelayW-1:0]  delay;
        logic [PeriodW-1:0]        period;
        logic                      once;
    } entry_t;

    typedef struct packed {
        logic [1:0]         func;
        logic [IdW-1:0]     task_id;
        logic [15:0]        first_delay;
        logic [PeriodW-1:0] task_period;
        logic               one_shot;
        logic [5:0]         slot_index;
    } cmd_t;

    typedef struct packed {
        logic           push;
        logic [IdW-1:0] id;
    } disp_t;

    typedef struct packed {
        logic            done;
        logic [1:0]      err;
        logic [NumW-1:0] ndisp;
        logic [6:0]      count;
    } summ_t;

endpackage

// ===== sv/hts_ram.sv =====
// Entry memory of the heap: one write port, one registered read port.
`timescale 1ns / 1ps
module hts_ram #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  hts_pkg::entry_t             wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output hts_pkg::entry_t             rd_data
);

    hts_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // A read of the entry being written returns the new data.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data <= wr_data;
            end
            else
            begin
                rd_data <= mem[rd_addr];
            end
        end
    end

endmodule

// ===== sv/hts_seq.sv =====
// Heap sequencer: add, delete, tick, sift and subtraction passes over the entry memory.
`timescale 1ns / 1ps
module hts_seq #(
    parameter int MAX_TASKS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  hts_pkg::cmd_t   cmd,
    output hts_pkg::disp_t  disp,
    output hts_pkg::summ_t  summ
);

    localparam int AddrW = $clog2(MAX_TASKS);
    localparam int CntW  = $clog2(MAX_TASKS + 1);
    localparam int PW    = AddrW + 2;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_ADD_RD  = 4'd1;
    localparam logic [3:0] S_ADD_CMP = 4'd2;
    localparam logic [3:0] S_LAST_RD = 4'd3;
    localparam logic [3:0] S_LAST_LD = 4'd4;
    localparam logic [3:0] S_SD_RL   = 4'd5;
    localparam logic [3:0] S_SD_RR   = 4'd6;
    localparam logic [3:0] S_SD_CMP  = 4'd7;
    localparam logic [3:0] S_TK_LD   = 4'd8;
    localparam logic [3:0] S_SUB     = 4'd9;
    localparam logic [3:0] S_RESCH   = 4'd10;
    localparam logic [3:0] S_TK_RD   = 4'd11;
    localparam logic [3:0] S_TK_CHK  = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0]                       state_reg, state_next;
    logic [1:0]                       op_reg, op_next;
    hts_pkg::entry_t                  cur_reg, cur_next;
    hts_pkg::entry_t                  lft_reg, lft_next;
    logic [AddrW-1:0]                 pos_reg, pos_next;
    logic [CntW-1:0]                  held_reg, held_next;
    logic signed [hts_pkg::DelayW-1:0] ref_reg, ref_next;
    logic [hts_pkg::NumW-1:0]         ndisp_reg, ndisp_next;
    logic [1:0]                       err_reg, err_next;
    logic [AddrW-1:0]                 sub_reg, sub_next;

    logic                             wr_en, rd_en;
    logic [AddrW-1:0]                 wr_addr, rd_addr;
    hts_pkg::entry_t                  wr_data, rd_data;

    logic [PW-1:0]                    l_w, r_w, held_p;
    logic                             l_ok, r_ok;
    logic [AddrW-1:0]                 pos_m1, parent;
    logic                             pick_l, pick_r;
    logic signed [hts_pkg::DelayW-1:0] key;
    hts_pkg::entry_t                  tk_ent;
    logic signed [hts_pkg::DelayW:0]  sub_w;
    hts_pkg::entry_t                  sub_ent;
    logic [CntW-1:0]                  sub_nx;

    hts_ram #(
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign l_w    = {1'b0, pos_reg, 1'b1};
    assign r_w    = l_w + PW'(1);
    assign held_p = PW'(held_reg);
    assign l_ok   = l_w < held_p;
    assign r_ok   = r_w < held_p;
    assign pos_m1 = pos_reg - AddrW'(1);
    assign parent = pos_m1 >> 1;

    assign pick_l = $signed(lft_reg.delay) <= $signed(cur_reg.delay);
    assign key    = pick_l ? lft_reg.delay : cur_reg.delay;
    assign pick_r = r_ok && ($signed(rd_data.delay) <= $signed(key));

    // Root after the tick decrement.
    always_comb
    begin
        tk_ent = rd_data;
        if ($signed(rd_data.delay) > 0)
        begin
            tk_ent.delay = rd_data.delay - hts_pkg::DelayW'(1);
        end
    end

    // Entry after the subtraction, saturated at the delay floor.
    always_comb
    begin
        sub_w   = {rd_data.delay[hts_pkg::DelayW-1], rd_data.delay}
                - {ref_reg[hts_pkg::DelayW-1], ref_reg};
        sub_ent = rd_data;
        if (sub_w[hts_pkg::DelayW] && !sub_w[hts_pkg::DelayW-1])
        begin
            sub_ent.delay = hts_pkg::DELAY_FLOOR;
        end
        else
        begin
            sub_ent.delay = sub_w[hts_pkg::DelayW-1:0];
        end
    end

    assign sub_nx = CntW'(sub_reg) + CntW'(1);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cur_next   = cur_reg;
        lft_next   = lft_reg;
        pos_next   = pos_reg;
        held_next  = held_reg;
        ref_next   = ref_reg;
        ndisp_next = ndisp_reg;
        err_next   = err_reg;
        sub_next   = sub_reg;
        rd_en      = 1'b0;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = pos_reg;
        wr_data    = cur_reg;
        disp.push  = 1'b0;
        disp.id    = rd_data.id;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next    = cmd.func;
                    err_next   = hts_pkg::ERR_NONE;
                    ndisp_next = '0;
                    if (cmd.func == hts_pkg::FUNC_ADD)
                    begin
                        if (held_reg == CntW'(MAX_TASKS))
                        begin
                            err_next   = hts_pkg::ERR_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            cur_next.id     = cmd.task_id;
                            cur_next.delay  = {1'b0, cmd.first_delay};
                            cur_next.period = cmd.task_period;
                            cur_next.once   = cmd.one_shot;
                            pos_next        = AddrW'(held_reg);
                            state_next      = S_ADD_RD;
                        end
                    end
                    else if (cmd.func == hts_pkg::FUNC_DEL)
                    begin
                        if ({1'b0, cmd.slot_index} >= 7'(held_reg))
                        begin
                            err_next   = hts_pkg::ERR_NODEL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            held_next = held_reg - CntW'(1);
                            pos_next  = AddrW'(cmd.slot_index);
                            if ({1'b0, cmd.slot_index} == 7'(held_reg) - 7'd1)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_LAST_RD;
                            end
                        end
                    end
                    else if (cmd.func == hts_pkg::FUNC_TICK && held_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        state_next = S_TK_LD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_ADD_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    held_next  = held_reg + CntW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = parent;
                    state_next = S_ADD_CMP;
                end
            end
            S_ADD_CMP:
            begin
                wr_en = 1'b1;
                if ($signed(cur_reg.delay) < $signed(rd_data.delay))
                begin
                    wr_data    = rd_data;
                    pos_next   = parent;
                    state_next = S_ADD_RD;
                end
                else
                begin
                    held_next  = held_reg + CntW'(1);
                    state_next = S_DONE;
                end
            end
            S_LAST_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = AddrW'(held_reg);
                state_next = S_LAST_LD;
            end
            S_LAST_LD:
            begin
                cur_next   = rd_data;
                state_next = S_SD_RL;
            end
            S_SD_RL:
            begin
                if (l_ok)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = l_w[AddrW-1:0];
                    state_next = S_SD_RR;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = (op_reg == hts_pkg::FUNC_TICK) ? S_TK_RD : S_DONE;
                end
            end
            S_SD_RR:
            begin
                lft_next = rd_data;
                if (r_ok)
                begin
                    rd_en   = 1'b1;
                    rd_addr = r_w[AddrW-1:0];
                end
                state_next = S_SD_CMP;
            end
            S_SD_CMP:
            begin
                wr_en = 1'b1;
                priority if (pick_r)
                begin
                    wr_data    = rd_data;
                    pos_next   = r_w[AddrW-1:0];
                    state_next = S_SD_RL;
                end
                else if (pick_l)
                begin
                    wr_data    = lft_reg;
                    pos_next   = l_w[AddrW-1:0];
                    state_next = S_SD_RL;
                end
                else
                begin
                    state_next = (op_reg == hts_pkg::FUNC_TICK) ? S_TK_RD : S_DONE;
                end
            end
            S_TK_LD:
            begin
                cur_next = tk_ent;
                if ($signed(tk_ent.delay) > 0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    wr_data    = tk_ent;
                    state_next = S_DONE;
                end
                else
                begin
                    disp.push  = 1'b1;
                    ndisp_next = hts_pkg::NumW'(1);
                    if ($signed(ref_reg) > 0 && held_reg > CntW'(1))
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = AddrW'(1);
                        sub_next   = AddrW'(1);
                        state_next = S_SUB;
                    end
                    else
                    begin
                        state_next = S_RESCH;
                    end
                end
            end
            S_SUB:
            begin
                // Write back one entry while the next one is read.
                wr_en   = 1'b1;
                wr_addr = sub_reg;
                wr_data = sub_ent;
                if (sub_nx < held_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = sub_nx[AddrW-1:0];
                    sub_next = sub_nx[AddrW-1:0];
                end
                else
                begin
                    state_next = S_RESCH;
                end
            end
            S_RESCH:
            begin
                pos_next = '0;
                if (cur_reg.once)
                begin
                    held_next  = held_reg - CntW'(1);
                    state_next = (held_reg == CntW'(1)) ? S_TK_RD : S_LAST_RD;
                end
                else
                begin
                    cur_next.delay = (cur_reg.period == '0) ? hts_pkg::DelayW'(1)
                                                            : {1'b0, cur_reg.period};
                    state_next     = S_SD_RL;
                end
            end
            S_TK_RD:
            begin
                if (held_reg == '0)
                begin
                    ref_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = S_TK_CHK;
                end
            end
            S_TK_CHK:
            begin
                if ($signed(rd_data.delay) <= 0
                    && ndisp_reg < hts_pkg::NumW'(hts_pkg::ResultLimit))
                begin
                    disp.push  = 1'b1;
                    ndisp_next = ndisp_reg + hts_pkg::NumW'(1);
                    cur_next   = rd_data;
                    state_next = S_RESCH;
                end
                else
                begin
                    ref_next   = rd_data.delay;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            held_reg  <= '0;
            ref_reg   <= '0;
            ndisp_reg <= '0;
            err_reg   <= hts_pkg::ERR_NONE;
            op_reg    <= hts_pkg::FUNC_ADD;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
            ref_reg   <= ref_next;
            ndisp_reg <= ndisp_next;
            err_reg   <= err_next;
            op_reg    <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        lft_reg <= lft_next;
        pos_reg <= pos_next;
        sub_reg <= sub_next;
    end

    assign summ.done  = (state_reg == S_DONE);
    assign summ.err   = err_reg;
    assign summ.ndisp = ndisp_reg;
    assign summ.count = 7'(held_reg);

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CntW'(MAX_TASKS))
        else $error("held count above capacity");

    a_ndisp_range: assert property (@(posedge clk) disable iff (!rst_n)
        ndisp_reg <= hts_pkg::NumW'(hts_pkg::ResultLimit))
        else $error("too many dispatches in one tick");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == S_IDLE)
        else $error("start while busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |=> state_reg == S_IDLE)
        else $error("sequencer did not return to idle");

    a_push_tick: assert property (@(posedge clk) disable iff (!rst_n)
        disp.push |-> op_reg == hts_pkg::FUNC_TICK)
        else $error("dispatch outside a tick");

endmodule

// ===== sv/heap_task_scheduler.sv =====
// Heap task scheduler top level: input capture, dispatch buffer and result register.
//
// Input channel (in_valid/in_ready) takes one command word: func selects add,
// tick or delete, with task_id, first_delay, task_period, one_shot and
// slot_index as its operands. Output channel (out_valid/out_ready) returns
// one result word for an add, a delete, an idle tick or an unused func code,
// and one word for each dispatched task of a tick (up to 16); last marks the
// final word of a command. An add sifts the new entry up the heap; a delete
// or a reschedule sifts an entry down through the entry memory. A dispatching
// tick may add a subtraction pass over the other held tasks, and a sift per
// dispatch. Commands are handled one at a time; the next one is taken once all
// results of the current one sit in or have left the output register. Reset
// empties the scheduler. A stalled receiver holds the output register and
// with it the flow of results.
`timescale 1ns / 1ps
module heap_task_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [7:0]  task_id,
    input  logic [15:0] first_delay,
    input  logic [15:0] task_period,
    input  logic        one_shot,
    input  logic [5:0]  slot_index,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        dispatched,
    output logic [7:0]  run_id,
    output logic [1:0]  error,
    output logic        last,
    output logic [6:0]  task_count
);

    hts_pkg::cmd_t   cmd;
    hts_pkg::disp_t  disp;
    hts_pkg::summ_t  summ;
    logic            start;

    logic                         busy_reg, busy_next;
    logic                         emit_reg, emit_next;
    logic [hts_pkg::BufW-1:0]     wptr_reg, wptr_next;
    logic [hts_pkg::BufW-1:0]     k_reg, k_next;
    logic [hts_pkg::NumW-1:0]     total_reg, total_next;
    logic                         any_reg, any_next;
    logic [1:0]                   err_reg, err_next;
    logic [6:0]                   cnt_reg, cnt_next;
    logic [hts_pkg::IdW-1:0]      ids [hts_pkg::ResultLimit];

    logic                         out_valid_reg, out_valid_next;
    logic                         dispatched_reg, dispatched_next;
    logic [7:0]                   run_id_reg, run_id_next;
    logic [1:0]                   error_reg, error_next;
    logic                         last_reg, last_next;
    logic [6:0]                   task_count_reg, task_count_next;
    logic                         load_ok, is_last;

    assign cmd.func        = func;
    assign cmd.task_id     = task_id;
    assign cmd.first_delay = first_delay;
    assign cmd.task_period = task_period;
    assign cmd.one_shot    = one_shot;
    assign cmd.slot_index  = slot_index;

    assign in_ready = !busy_reg && !emit_reg;
    assign start    = in_valid && in_ready;

    hts_seq #(
        .MAX_TASKS (MAX_TASKS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .disp  (disp),
        .summ  (summ)
    );

    always_ff @(posedge clk)
    begin
        if (disp.push)
        begin
            ids[wptr_reg] <= disp.id;
        end
    end

    assign load_ok = !out_valid_reg || out_ready;
    assign is_last = ({1'b0, k_reg} + hts_pkg::NumW'(1)) == total_reg;

    always_comb
    begin
        busy_next       = busy_reg;
        emit_next       = emit_reg;
        wptr_next       = wptr_reg;
        k_next          = k_reg;
        total_next      = total_reg;
        any_next        = any_reg;
        err_next        = err_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        dispatched_next = dispatched_reg;
        run_id_next     = run_id_reg;
        error_next      = error_reg;
        last_next       = last_reg;
        task_count_next = task_count_reg;
        if (start)
        begin
            busy_next = 1'b1;
            wptr_next = '0;
        end
        if (disp.push)
        begin
            wptr_next = wptr_reg + hts_pkg::BufW'(1);
        end
        if (summ.done)
        begin
            busy_next  = 1'b0;
            emit_next  = 1'b1;
            k_next     = '0;
            any_next   = summ.ndisp != '0;
            total_next = (summ.ndisp == '0) ? hts_pkg::NumW'(1) : summ.ndisp;
            err_next   = summ.err;
            cnt_next   = summ.count;
        end
        if (emit_reg && load_ok)
        begin
            out_valid_next  = 1'b1;
            dispatched_next = any_reg;
            run_id_next     = any_reg ? ids[k_reg] : '0;
            error_next      = err_reg;
            last_next       = is_last;
            task_count_next = cnt_reg;
            k_next          = k_reg + hts_pkg::BufW'(1);
            if (is_last)
            begin
                emit_next = 1'b0;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            wptr_reg      <= '0;
            k_reg         <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
            wptr_reg      <= wptr_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg      <= total_next;
        any_reg        <= any_next;
        err_reg        <= err_next;
        cnt_reg        <= cnt_next;
        dispatched_reg <= dispatched_next;
        run_id_reg     <= run_id_next;
        error_reg      <= error_next;
        last_reg       <= last_next;
        task_count_reg <= task_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign dispatched = dispatched_reg;
    assign run_id     = run_id_reg;
    assign error      = error_reg;
    assign last       = last_reg;
    assign task_count = task_count_reg;

    a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy_reg && emit_reg))
        else $error("sequencer busy while results are pending");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        summ.done |-> busy_reg)
        else $error("summary without a command in progress");

    a_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
        disp.push |-> busy_reg && !emit_reg)
        else $error("dispatch word outside a command");

endmodule

// ===== sim/tb_heap_task_scheduler.sv =====
// Self-checking testbench of the heap task scheduler: random and directed commands.
`timescale 1ns / 1ps
module tb_heap_task_scheduler;

    localparam int Slots = 16;
    localparam int Floor = -65536;
    localparam logic [1:0] FuncSpare = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  task_id;
        logic [15:0] first_delay;
        logic [15:0] task_period;
        logic        one_shot;
        logic [5:0]  slot_index;
    } command_t;

    typedef struct packed {
        logic       dispatched;
        logic [7:0] run_id;
        logic [1:0] error;
        logic       last;
        logic [6:0] task_count;
    } outcome_t;

    typedef struct {
        logic [7:0]  id;
        int          delay;
        logic [15:0] period;
        logic        once;
    } timer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] func = '0;
    logic [7:0] task_id = '0;
    logic [15:0] first_delay = '0;
    logic [15:0] task_period = '0;
    logic one_shot = 1'b0;
    logic [5:0] slot_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic dispatched;
    logic [7:0] run_id;
    logic [1:0] error;
    logic last;
    logic [6:0] task_count;

    heap_task_scheduler #(.MAX_TASKS(Slots)) dut (.*);

    always #1 clk = ~clk;

    command_t pending_cmds[$];
    outcome_t expected_words[$];
    timer_t heap[Slots];
    int held = 0;
    int root_ref = 0;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;

    function automatic void swap_timers(int a, int b);
        timer_t t;
        t = heap[a];
        heap[a] = heap[b];
        heap[b] = t;
    endfunction

    function automatic void sift_down(int idx);
        int pick;
        int l;
        forever
        begin
            pick = idx;
            l = 2 * idx + 1;
            if (l >= held)
                return;
            if (heap[l].delay <= heap[pick].delay)
                pick = l;
            if (l + 1 < held && heap[l + 1].delay <= heap[pick].delay)
                pick = l + 1;
            if (pick == idx)
                return;
            swap_timers(idx, pick);
            idx = pick;
        end
    endfunction

    function automatic void drop_slot(int idx);
        held--;
        if (idx != held)
        begin
            heap[idx] = heap[held];
            sift_down(idx);
        end
    endfunction

    function automatic void rearm_root();
        if (heap[0].once)
            drop_slot(0);
        else
        begin
            heap[0].delay = (heap[0].period == 0) ? 1 : int'(heap[0].period);
            sift_down(0);
        end
    endfunction

    // Computes the result words of one command and advances the heap copy.
    function automatic void schedule_step(command_t c);
        outcome_t words[$];
        outcome_t w;
        int pos;
        int d;
        w = '0;
        if (c.func == hts_pkg::FUNC_ADD)
        begin
            if (held >= Slots)
                w.error = hts_pkg::ERR_FULL;
            else
            begin
                pos = held;
                heap[pos].id = c.task_id;
                heap[pos].delay = int'(c.first_delay);
                heap[pos].period = c.task_period;
                heap[pos].once = c.one_shot;
                while (pos > 0 && heap[pos].delay < heap[(pos - 1) / 2].delay)
                begin
                    swap_timers(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
                held++;
            end
            words.push_back(w);
        end
        else if (c.func == hts_pkg::FUNC_DEL)
        begin
            if (int'(c.slot_index) >= held)
                w.error = hts_pkg::ERR_NODEL;
            else
                drop_slot(int'(c.slot_index));
            words.push_back(w);
        end
        else if (c.func == hts_pkg::FUNC_TICK && held > 0)
        begin
            if (heap[0].delay > 0)
                heap[0].delay--;
            if (heap[0].delay <= 0)
            begin
                w.dispatched = 1'b1;
                w.run_id = heap[0].id;
                words.push_back(w);
                if (root_ref > 0)
                    for (int i = 1; i < held; i++)
                    begin
                        d = heap[i].delay - root_ref;
                        heap[i].delay = (d < Floor) ? Floor : d;
                    end
                rearm_root();
                while (held > 0 && heap[0].delay <= 0
                       && words.size() < hts_pkg::ResultLimit)
                begin
                    w.run_id = heap[0].id;
                    words.push_back(w);
                    rearm_root();
                end
                root_ref = (held > 0) ? heap[0].delay : 0;
            end
            else
                words.push_back(w);
        end
        else
            words.push_back(w);
        foreach (words[k])
        begin
            words[k].task_count = 7'(held);
            words[k].last = (k == words.size() - 1);
            expected_words.push_back(words[k]);
        end
    endfunction

    // Driver: offers queued commands and predicts each on acceptance.
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            schedule_step('{func, task_id, first_delay, task_period, one_shot, slot_index});
        if ((!in_valid || in_ready) && rst_n)
        begin
            if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                {func, task_id, first_delay, task_period, one_shot, slot_index}
                    <= pending_cmds.pop_front();
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor: compares each result word with the oldest expectation.
    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (out_valid && out_ready)
        begin
            got = '{dispatched, run_id, error, last, task_count};
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, actual %p", $realtime, got);
                errors++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch, expected %p, actual %p", $realtime, want, got);
                    errors++;
                end
            end
        end
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic command_t add_cmd(logic [7:0] id, logic [15:0] dly, logic [15:0] per,
                                         logic once);
        command_t c;
        c = '0;
        c.func = hts_pkg::FUNC_ADD;
        c.task_id = id;
        c.first_delay = dly;
        c.task_period = per;
        c.one_shot = once;
        c.slot_index = 6'($urandom);
        return c;
    endfunction

    function automatic command_t tick_cmd();
        command_t c;
        c = command_t'(49'({$urandom, $urandom}));
        c.func = hts_pkg::FUNC_TICK;
        return c;
    endfunction

    function automatic command_t del_cmd(logic [5:0] slot);
        command_t c;
        c = command_t'(49'({$urandom, $urandom}));
        c.func = hts_pkg::FUNC_DEL;
        c.slot_index = slot;
        return c;
    endfunction

    // Random command; the table size is tracked loosely, so deletes may miss.
    function automatic command_t random_cmd(int est);
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return add_cmd(8'($urandom),
                           ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6)),
                           ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5)),
                           1'($urandom));
        if (r < 85)
            return tick_cmd();
        if (r < 97)
            return del_cmd((est > 0 && $urandom_range(3) != 0) ?
                           6'($urandom_range(est - 1)) : 6'($urandom));
        return command_t'({FuncSpare, 47'($urandom)});
    endfunction

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || in_valid || expected_words.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        int est;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty cases, field extremes, full table, floor saturation.
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(del_cmd(6'd0));
        pending_cmds.push_back(command_t'({FuncSpare, 47'h7FFF_FFFF_FFFF}));
        pending_cmds.push_back(add_cmd(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0));
        pending_cmds.push_back(add_cmd(8'h00, 16'h0000, 16'h0000, 1'b0));
        pending_cmds.push_back(add_cmd(8'h55, 16'h0001, 16'h0000, 1'b1));
        pending_cmds.push_back(add_cmd(8'hAA, 16'h0000, 16'h0002, 1'b1));
        for (int i = 0; i < 14; i++)
            pending_cmds.push_back(add_cmd(8'(i + 16), 16'h0000, 16'(i & 1), 1'b0));
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(tick_cmd());
        pending_cmds.push_back(del_cmd(6'd63));
        pending_cmds.push_back(del_cmd(6'd0));
        wait_drained();

        // Clear the table, then check the holdoff with a pile of queued words.
        for (int i = 0; i < 17; i++)
            pending_cmds.push_back(del_cmd(6'd0));
        hold_off = 400;
        for (int i = 0; i < 8; i++)
            pending_cmds.push_back(add_cmd(8'($urandom), 16'($urandom_range(3)),
                                           16'($urandom_range(2)), 1'($urandom)));
        wait_drained();

        est = 8;
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 87 : 32) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 87 : 32) : 0;
            for (int i = 0; i < 15; i++)
            begin
                pending_cmds.push_back(random_cmd(est));
                if (pending_cmds[$].func == hts_pkg::FUNC_ADD && est < Slots)
                    est++;
                else if (pending_cmds[$].func == hts_pkg::FUNC_DEL && est > 0)
                    est--;
            end
            wait_drained();
        end

        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end
endmodule
